>>> hdl/ps_pkg.sv
`timescale 1ns / 1ps

package ps_pkg;

  // Chain size and candidate limits
  localparam int STAGES        = 16;
  localparam int MAX_CANDIDATE = 65535;
  localparam int MIN_PRIME     = 2;

  localparam int DATA_W = 16;
  localparam int IDX_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int CNT_W  = $clog2(STAGES + 1);

  // Remainder unit: DIV_BITS quotient bits retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = DATA_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

>>> hdl/ps_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module ps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ps_mod.sv
`timescale 1ns / 1ps

// Iterative restoring remainder, DIV_BITS bits per cycle.
module ps_mod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ps_pkg::div_req_t req_i,
  output ps_pkg::div_rsp_t rsp_o
);

  logic [ps_pkg::DATA_W-1:0]    rem_q, rem_d;
  logic [ps_pkg::DATA_W-1:0]    dvd_q, dvd_d;
  logic [ps_pkg::DATA_W-1:0]    div_q;
  logic [ps_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                         done_q, done_d;

  always_comb begin
    logic [ps_pkg::DATA_W:0]   t;
    logic [ps_pkg::DATA_W-1:0] r;
    logic [ps_pkg::DATA_W-1:0] s;
    r = rem_q;
    s = dvd_q;
    for (int i = 0; i < ps_pkg::DIV_BITS; i++) begin
      t = {r, s[ps_pkg::DATA_W-1]};
      s = {s[ps_pkg::DATA_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[ps_pkg::DATA_W-1:0];
    end
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      dvd_d = req_i.dividend;
      cnt_d = ps_pkg::DIV_CNT_W'(ps_pkg::DIV_STEPS);
    end else if (cnt_q != '0) begin
      rem_d  = r;
      dvd_d  = s;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == ps_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (req_i.start) begin
      div_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

>>> hdl/pipelined_prime_sieve.sv
`timescale 1ns / 1ps

// Prime sieve over a chain of STAGES stored primes (16 by default). Feed
// candidates in ascending order from 2; each request is tested against the
// stored primes in stage order and either dropped (a stored prime divides
// it, or it is below 2) or returned as a prime together with the stage that
// now holds it. Once every stage is filled, survivors still come out but
// with chain_full set and stage_index 15, and are not stored. clear_first
// empties the chain before its own candidate is tested. One request is in
// flight at a time. After acceptance, each stored prime is read from its
// stage (S_CHECK), loaded into the remainder unit (S_LOAD) and tested for
// a zero remainder (S_DIV, until done); a final check in S_CHECK then leads
// to the result in S_FINISH, which holds while the output register is full
// and stalled. The remainder unit retires four quotient bits per cycle. A
// finished result waits in the output register while the next request is
// already accepted.
module pipelined_prime_sieve (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ps_pkg::DATA_W-1:0] candidate_i,
  input  logic                      clear_first_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ps_pkg::DATA_W-1:0] prime_value_o,
  output logic [3:0]                stage_index_o,
  output logic                      chain_full_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_LOAD   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Chain fill level and scan pointer
  logic [ps_pkg::CNT_W-1:0]  used_q, used_d;
  logic [ps_pkg::CNT_W-1:0]  k_q, k_d;
  logic [ps_pkg::DATA_W-1:0] cand_q;

  logic                      out_valid_q, out_valid_d;
  logic [ps_pkg::DATA_W-1:0] out_prime_q;
  logic [3:0]                out_index_q;
  logic                      out_full_q;

  logic in_accept;
  logic out_accept;
  logic out_load;
  logic chain_is_full;
  logic [31:0] used_wide;

  // Memory and remainder unit hookup
  logic                      mem_we;
  logic                      mem_re;
  logic [ps_pkg::DATA_W-1:0] mem_rdata;
  ps_pkg::div_req_t          div_req;
  ps_pkg::div_rsp_t          div_rsp;

  assign in_stall_o    = (state_q != S_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_accept    = out_valid_q && !out_stall_i;
  assign chain_is_full = (used_q == ps_pkg::CNT_W'(ps_pkg::STAGES));
  assign used_wide     = 32'(used_q);

  always_comb begin
    state_d          = state_q;
    used_d           = used_q;
    k_d              = k_q;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cand_q;
    div_req.divisor  = mem_rdata;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (clear_first_i) begin
            used_d = '0;
          end
          k_d = '0;
          // Below two or above the limit: dropped, only the clear takes effect
          if (!(candidate_i < ps_pkg::DATA_W'(ps_pkg::MIN_PRIME) ||
                candidate_i > ps_pkg::DATA_W'(ps_pkg::MAX_CANDIDATE))) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (k_q == used_q) begin
          state_d = S_FINISH;
        end else begin
          mem_re  = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (!chain_is_full) begin
            mem_we = 1'b1;
            used_d = used_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_accept) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cand_q <= candidate_i;
    end
    if (out_load) begin
      out_prime_q <= cand_q;
      out_index_q <= chain_is_full ? 4'hF : used_wide[3:0];
      out_full_q  <= chain_is_full;
    end
  end

  // Reads and writes never overlap: a write only happens in S_FINISH, after
  // the scan is done, so no forwarding path is needed.
  ps_ram #(
    .WIDTH (ps_pkg::DATA_W),
    .DEPTH (ps_pkg::STAGES)
  ) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (used_q[ps_pkg::IDX_W-1:0]),
    .wdata_i (cand_q),
    .re_i    (mem_re),
    .raddr_i (k_q[ps_pkg::IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  ps_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = out_prime_q;
  assign stage_index_o = out_index_q;
  assign chain_full_o  = out_full_q;

  // Fill level never exceeds the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= ps_pkg::CNT_W'(ps_pkg::STAGES))
    else $error("fill level beyond chain size");

  // Only filled stages are ever read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (k_q < used_q))
    else $error("read of unfilled stage");

  // A stored prime grows the fill level by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (used_q == $past(used_q) + 1'b1))
    else $error("fill level not advanced on store");

  // A full-chain result is flagged at stage 15 and nothing is stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && chain_is_full) |=> (out_full_q && out_index_q == 4'hF &&
                                     used_q == $past(used_q)))
    else $error("full-chain result mishandled");

  // Remainder unit reports done only while its result is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("stray remainder done");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the prime sieve. Candidate requests are driven at the falling
// edge, and both handshakes are sampled at the rising edge. The testbench keeps
// its own copy of the stored primes. Each accepted request updates that copy
// and queues the result it should produce, if any. A monitor pops that queue
// for every accepted result and compares it field by field.
module tb_top;

  localparam int         CLK_HALF   = 2;       // 4 ns period
  localparam int         RESET_CYC  = 11;
  localparam int         IDLE_LIMIT = 4000;    // cycles with no handshake at all
  localparam int         TAIL_CYC   = 200;     // settle after last result
  localparam int         RAND_ITEMS = 1350;
  localparam int         CALM_ITEMS = 150;     // final part, no idling anywhere
  localparam logic [3:0] FULL_INDEX = 4'd15;

  typedef struct packed {
    logic [ps_pkg::DATA_W-1:0] prime_value;
    logic [3:0]                stage_index;
    logic                      chain_full;
  } prime_rsp_t;

  // DUT ports
  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [ps_pkg::DATA_W-1:0] candidate_i;
  logic                      clear_first_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [ps_pkg::DATA_W-1:0] prime_value_o;
  logic [3:0]                stage_index_o;
  logic                      chain_full_o;

  // Mirror of the sieve chain
  logic [ps_pkg::DATA_W-1:0] held_primes [ps_pkg::STAGES];
  int                        held_count;
  prime_rsp_t                pending_primes [$];

  // Run control and tallies
  bit idle_on;
  int idle_cycles;
  int errors;
  int items_sent;
  int primes_seen;
  int full_seen;
  int stall_left;

  pipelined_prime_sieve DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .candidate_i   (candidate_i),
    .clear_first_i (clear_first_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .prime_value_o (prime_value_o),
    .stage_index_o (stage_index_o),
    .chain_full_o  (chain_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Chain mirror: clear first, drop out-of-range values and anything a held
  // prime divides, otherwise store in the next stage or flag the chain full.
  function automatic void predict_sieve(input logic [ps_pkg::DATA_W-1:0] cand,
                                        input logic clr);
    prime_rsp_t rsp;
    bit         divided;
    divided = 1'b0;
    if (clr) held_count = 0;
    if (cand < ps_pkg::MIN_PRIME || cand > ps_pkg::MAX_CANDIDATE) return;
    for (int k = 0; k < held_count; k++) begin
      if (cand % held_primes[k] == 0) divided = 1'b1;
    end
    if (divided) return;
    rsp.prime_value = cand;
    if (held_count < ps_pkg::STAGES) begin
      held_primes[held_count] = cand;
      rsp.stage_index = 4'(held_count);
      rsp.chain_full  = 1'b0;
      held_count++;
    end else begin
      rsp.stage_index = FULL_INDEX;
      rsp.chain_full  = 1'b1;
    end
    pending_primes.push_back(rsp);
  endfunction

  // One candidate request. An optional idle burst comes first; the payload
  // then holds until the sieve takes it.
  task automatic send_candidate(input logic [ps_pkg::DATA_W-1:0] cand, input logic clr);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    candidate_i   = cand;
    clear_first_i = clr;
    do @(posedge clk_i); while (in_stall_o);
    predict_sieve(cand, clr);
    items_sent++;
  endtask

  // Clear, then count upward from start. Values stop at the top of the range.
  task automatic send_stream(input int start, input int len);
    for (int v = start; v < start + len && v <= ps_pkg::MAX_CANDIDATE; v++) begin
      send_candidate(ps_pkg::DATA_W'(v), v == start);
    end
  endtask

  // Hold the sender off until every queued prime has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_primes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver side: random stall bursts while idling is on
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (!idle_on) begin
        out_stall_i = 1'b0;
        stall_left  = 0;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        stall_left  = $urandom_range(0, 7);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Result checker and handshake activity tracking
  always @(posedge clk_i) begin
    prime_rsp_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        primes_seen++;
        if (chain_full_o) full_seen++;
        if (pending_primes.size() == 0) begin
          $error("unexpected result: prime_value %0d stage_index %0d chain_full %0b",
                 prime_value_o, stage_index_o, chain_full_o);
          errors++;
        end else begin
          want = pending_primes.pop_front();
          if (prime_value_o !== want.prime_value) begin
            $error("prime_value: expected %0d, got %0d", want.prime_value, prime_value_o);
            errors++;
          end
          if (stage_index_o !== want.stage_index) begin
            $error("stage_index: expected %0d, got %0d", want.stage_index, stage_index_o);
            errors++;
          end
          if (chain_full_o !== want.chain_full) begin
            $error("chain_full: expected %0b, got %0b", want.chain_full, chain_full_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("tb_top failed");
    $finish;
  end

  // Edge values, drops below two, repeats, clear with a dropped candidate
  task automatic test_directed();
    send_candidate(16'd0, 1'b1);      // below two, dropped
    send_candidate(16'd1, 1'b0);      // below two, dropped
    send_candidate(16'd2, 1'b0);      // stage 0
    send_candidate(16'd3, 1'b0);
    send_candidate(16'd4, 1'b0);      // divisible, dropped
    send_candidate(16'd5, 1'b0);
    send_candidate(16'd2, 1'b0);      // repeat of a held prime
    send_candidate(16'd7, 1'b0);
    send_candidate(16'd65535, 1'b0);  // top of range, 3 divides it
    send_candidate(16'd1, 1'b1);      // clear, candidate itself dropped
    send_candidate(16'd65521, 1'b0);  // largest 16-bit prime into stage 0
    send_candidate(16'd65535, 1'b0);  // top of range, held prime does not divide
    send_candidate(16'd0, 1'b1);      // clear with zero
    send_candidate(16'd65535, 1'b0);  // top of range with empty chain
    send_candidate(16'd32768, 1'b0);
    send_candidate(16'd2, 1'b0);      // divides 32768, but lower than it
    send_candidate(16'd3, 1'b1);
    send_candidate(16'd9, 1'b0);      // 3 divides it, dropped
    send_candidate(16'd11, 1'b0);
  endtask

  // Ascending from 2 far enough that the chain fills and survivors get flagged
  task automatic test_full_chain();
    send_stream(ps_pkg::MIN_PRIME, 140);
  endtask

  // Mostly well-formed ascending streams, some from a random start, the
  // rest loose noise with random clears and out-of-order values.
  task automatic test_random_streams();
    int sent_at_start;
    int pick;
    sent_at_start = items_sent;
    while (items_sent - sent_at_start < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_stream(ps_pkg::MIN_PRIME, $urandom_range(1, 120));
      end else if (pick < 80) begin
        send_stream($urandom_range(ps_pkg::MIN_PRIME, ps_pkg::MAX_CANDIDATE),
                    $urandom_range(1, 30));
      end else begin
        repeat ($urandom_range(1, 10))
          send_candidate(ps_pkg::DATA_W'($urandom()), ($urandom_range(0, 7) == 0));
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  // Sender waits for a full drain before going on
  task automatic test_drain_pause();
    send_stream(ps_pkg::MIN_PRIME, 30);
    drain_results();
    send_candidate(16'd31, 1'b0);     // held already, dropped
    send_candidate(16'd37, 1'b0);
  endtask

  // Last part at full rate on both sides
  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_stream(ps_pkg::MIN_PRIME, CALM_ITEMS - 20);
    repeat (20) send_candidate(ps_pkg::DATA_W'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    candidate_i   = '0;
    clear_first_i = 1'b0;
    held_count    = 0;
    idle_on       = 1'b1;
    items_sent    = 0;
    repeat (RESET_CYC) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_chain();
    test_drain_pause();
    test_random_streams();
    test_back_to_back();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_primes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("Sent %0d candidate requests; checked %0d primes, %0d of them past a full chain.",
             items_sent, primes_seen, full_seen);
    $display("Covered drops below two, repeats, clears, full chain and stalls on both sides.");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ps_pkg.sv
hdl/ps_ram.sv
hdl/ps_mod.sv
hdl/pipelined_prime_sieve.sv
tb/tb_top.sv
